// ===== hw/rtl/swsfd_pkg.sv =====
// types and constants shared by the sync-word frame deframer modules
// no dependencies
package swsfd_pkg;

    localparam int DATA_BYTES = 13;

    localparam logic [3:0] POS_HUNT   = 4'd0;
    localparam logic [3:0] POS_SYNC2  = 4'd1;
    localparam logic [3:0] DATA_FIRST = 4'd2;
    localparam logic [3:0] FRAME_LAST = 4'd15;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAB;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hCD;
    localparam logic [7:0] END_MARKER_RST  = 8'h88;

    typedef enum logic [1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_END_MARKER  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       channel;
    } t_item;

    typedef struct packed {
        logic               source_channel;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic        [7:0]  temperature;
    } t_result;

    // work passed from the front end to the frame store
    typedef struct packed {
        logic       emit;
        logic       ch;
        logic [3:0] slot;
        logic [7:0] data;
    } t_cmd;

endpackage

// ===== hw/rtl/sync_word_sensor_frame_deframer_core.sv =====
// a frame's last byte passes through the command queue and then the result queue, and shows
// as a result once the result queue has room
// throughput: one byte per cycle; full rises only when the 4-entry command queue
// between front and back fills, which needs the 2-entry result queue to back up
// reset: synchronous, clears byte positions and both queues, sets config registers to
// their reset values; the frame byte store is not cleared
module sync_word_sensor_frame_deframer_core #(
    parameter int CHANNELS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  swsfd_pkg::t_item   i_item,
    output logic               empty,
    input  logic               pop,
    output swsfd_pkg::t_result o_result,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_wdata
);
    import swsfd_pkg::*;

    logic cmd_push;
    logic cmd_pop;
    logic cmd_empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    swsfd_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_push      (push),
        .i_cmd_full  (full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    swsfd_fifo #(
        .WIDTH($bits(t_cmd)),
        .DEPTH(4)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    swsfd_back #(
        .CHANNELS(CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

// ===== hw/rtl/swsfd_fifo.sv =====
// small first-word-fall-through queue of register entries
// no dependencies
module swsfd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (push_ok) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        case ({push_ok, pop_ok})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/swsfd_front.sv =====
// front end: per-channel sync hunt and byte position tracking, config registers
// depends on swsfd_pkg
module swsfd_front #(
    parameter int CHANNELS = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  swsfd_pkg::t_item i_item,
    input  logic             i_push,
    input  logic             i_cmd_full,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_wdata,
    output logic             o_cmd_push,
    output swsfd_pkg::t_cmd  o_cmd
);
    import swsfd_pkg::*;

    localparam int ROWS = (CHANNELS > 2) ? 2 : CHANNELS;

    logic [3:0] r_pos [ROWS];
    logic [3:0] n_pos [ROWS];
    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic [7:0] r_end_marker;
    logic       ch_ok;
    logic       take;
    logic [3:0] pos;

    assign ch_ok = (int'(i_item.channel) < CHANNELS);
    assign take  = i_push && !i_cmd_full && ch_ok;
    assign pos   = ch_ok ? r_pos[i_item.channel] : POS_HUNT;

    always_comb begin
        n_pos       = r_pos;
        o_cmd_push  = 1'b0;
        o_cmd.emit  = 1'b0;
        o_cmd.ch    = i_item.channel;
        o_cmd.slot  = pos - DATA_FIRST;
        o_cmd.data  = i_item.rx_byte;
        if (take) begin
            if (pos == POS_HUNT) begin
                if (i_item.rx_byte == r_sync_first) begin
                    n_pos[i_item.channel] = POS_SYNC2;
                end
            end else if (pos == POS_SYNC2) begin
                n_pos[i_item.channel] = (i_item.rx_byte == r_sync_second) ?
                                        DATA_FIRST : POS_HUNT;
            end else if (pos != FRAME_LAST) begin
                o_cmd_push            = 1'b1;
                n_pos[i_item.channel] = pos + 4'd1;
            end else begin
                n_pos[i_item.channel] = POS_HUNT;
                o_cmd.emit            = 1'b1;
                o_cmd_push            = (i_item.rx_byte == r_end_marker);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '{default: POS_HUNT};
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_end_marker  <= END_MARKER_RST;
        end else begin
            r_pos <= n_pos;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_wdata;
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg_wdata;
                    CFG_END_MARKER:  r_end_marker  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/swsfd_back.sv =====
// back end: per-channel frame byte store and result assembly into the output queue
// depends on swsfd_pkg and swsfd_fifo
module swsfd_back #(
    parameter int CHANNELS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swsfd_pkg::t_cmd    i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output swsfd_pkg::t_result o_result
);
    import swsfd_pkg::*;

    localparam int ROWS = (CHANNELS > 2) ? 2 : CHANNELS;

    logic [7:0] r_store [ROWS][DATA_BYTES];
    logic [7:0] row [DATA_BYTES];
    logic       out_full;
    logic       out_push;
    t_result    res;

    assign out_push  = !i_cmd_empty && i_cmd.emit && !out_full;
    assign o_cmd_pop = !i_cmd_empty && (!i_cmd.emit || !out_full);
    assign row       = r_store[i_cmd.ch];

    always_comb begin
        res.source_channel = i_cmd.ch;
        res.accel_x        = {row[0], row[1]};
        res.accel_y        = {row[2], row[3]};
        res.accel_z        = {row[4], row[5]};
        res.gyro_x         = {row[6], row[7]};
        res.gyro_y         = {row[8], row[9]};
        res.gyro_z         = {row[10], row[11]};
        res.temperature    = row[12];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && !i_cmd.emit) begin
            r_store[i_cmd.ch][i_cmd.slot] <= i_cmd.data;
        end
    end

    swsfd_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

// ===== hw/rtl/swsfd_checker.sv =====
// port-level checks for the deframer core, attached by bind
// depends on swsfd_pkg and sync_word_sensor_frame_deframer_core
module swsfd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input swsfd_pkg::t_result o_result
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input full after reset");

    a_full_by_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an input push");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

endmodule

bind sync_word_sensor_frame_deframer_core swsfd_checker u_chk (.*);

// ===== tb/sv/tb.sv =====
// self-checking testbench for sync_word_sensor_frame_deframer_core
// depends on swsfd_pkg and the core; a scoreboard class predicts completed frames
// from the accepted bytes and checks each popped result in order
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swsfd_pkg::*;

    localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_BYTES = 517;

    class frame_scoreboard;
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] end_marker;
        logic [3:0] position [2];
        logic [7:0] payload [2][DATA_BYTES];
        t_result    frames_due [$];
        int         errors;

        function new();
            sync_first  = SYNC_FIRST_RST;
            sync_second = SYNC_SECOND_RST;
            end_marker  = END_MARKER_RST;
            position[0] = POS_HUNT;
            position[1] = POS_HUNT;
            errors      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_SYNC_FIRST:  sync_first  = val;
                CFG_SYNC_SECOND: sync_second = val;
                CFG_END_MARKER:  end_marker  = val;
                default: ;
            endcase
        endfunction

        // returns 0 when the byte was ignored while hunting
        function bit note_item(t_item it);
            logic       ch;
            logic [7:0] b;
            logic [3:0] pos;
            t_result    r;
            bit         used;
            ch   = it.channel;
            b    = it.rx_byte;
            pos  = position[ch];
            used = 1'b1;
            if (pos == POS_HUNT) begin
                used = (b == sync_first);
                if (used) position[ch] = POS_SYNC2;
            end else if (pos == POS_SYNC2) begin
                position[ch] = (b == sync_second) ? DATA_FIRST : POS_HUNT;
            end else if (pos != FRAME_LAST) begin
                payload[ch][pos - DATA_FIRST] = b;
                position[ch] = pos + 4'd1;
            end else begin
                position[ch] = POS_HUNT;
                if (b == end_marker) begin
                    r.source_channel = ch;
                    r.accel_x        = {payload[ch][0], payload[ch][1]};
                    r.accel_y        = {payload[ch][2], payload[ch][3]};
                    r.accel_z        = {payload[ch][4], payload[ch][5]};
                    r.gyro_x         = {payload[ch][6], payload[ch][7]};
                    r.gyro_y         = {payload[ch][8], payload[ch][9]};
                    r.gyro_z         = {payload[ch][10], payload[ch][11]};
                    r.temperature    = payload[ch][12];
                    frames_due.push_back(r);
                end
            end
            return used;
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        function void check_field(string name, logic signed [16:0] e, logic signed [16:0] a);
            if (a !== e) begin
                $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (frames_due.size() == 0) begin
                $display("%0t unexpected frame: expected none, actual ch %0d accel_x %0d",
                         $realtime, got.source_channel, got.accel_x);
                errors++;
                return;
            end
            e = frames_due.pop_front();
            check_field("source_channel", e.source_channel, got.source_channel);
            check_field("accel_x", e.accel_x, got.accel_x);
            check_field("accel_y", e.accel_y, got.accel_y);
            check_field("accel_z", e.accel_z, got.accel_z);
            check_field("gyro_x", e.gyro_x, got.gyro_x);
            check_field("gyro_y", e.gyro_y, got.gyro_y);
            check_field("gyro_z", e.gyro_z, got.gyro_z);
            check_field("temperature", e.temperature, got.temperature);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_item      item_in;
    logic       empty;
    logic       pop;
    t_result    result;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [7:0] cfg_wdata;

    int send_idle;
    int recv_idle;
    logic [7:0] plan [2][$];

    frame_scoreboard sb = new();

    sync_word_sensor_frame_deframer_core #(.CHANNELS(2)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (item_in),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && pop && empty === 1'b0) sb.check_result(result);
        pop <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_item(input t_item it, output bit used);
        if ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        push    <= 1'b1;
        item_in <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        used = sb.note_item(it);
    endtask

    // lowers push and waits until the block has nothing left in flight
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] em);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_SYNC_FIRST;
        cfg_wdata <= s1;
        @(posedge i_clk);
        sb.write_reg(CFG_SYNC_FIRST, s1);
        cfg_idx   <= CFG_SYNC_SECOND;
        cfg_wdata <= s2;
        @(posedge i_clk);
        sb.write_reg(CFG_SYNC_SECOND, s2);
        cfg_idx   <= CFG_END_MARKER;
        cfg_wdata <= em;
        @(posedge i_clk);
        sb.write_reg(CFG_END_MARKER, em);
        // spare index must leave every register alone
        cfg_idx   <= CFG_IDX_SPARE;
        cfg_wdata <= ~em;
        @(posedge i_clk);
        sb.write_reg(CFG_IDX_SPARE, ~em);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic plan_frame(input int ch);
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 72) begin
            plan[ch].push_back(sb.sync_first);
            plan[ch].push_back(sb.sync_second);
            for (int i = 0; i < DATA_BYTES; i++) plan[ch].push_back(pick_byte());
            plan[ch].push_back(($urandom_range(99) < 85) ? sb.end_marker : pick_byte());
        end else if (kind < 82) begin
            // broken sync word, sometimes a repeated first sync byte
            plan[ch].push_back(sb.sync_first);
            plan[ch].push_back(($urandom_range(1) == 0) ? sb.sync_first : pick_byte());
        end else if (kind < 92) begin
            // sync then a short run, so the next frame lands mid-payload
            plan[ch].push_back(sb.sync_first);
            plan[ch].push_back(sb.sync_second);
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) plan[ch].push_back(pick_byte());
        end else begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) plan[ch].push_back(pick_byte());
        end
    endtask

    task automatic run_random(input int target, input bit hold_midway);
        int    used_count;
        int    ch;
        t_item it;
        bit    used;
        used_count = 0;
        while (used_count < target) begin
            ch = $urandom_range(1);
            if (plan[ch].size() == 0) plan_frame(ch);
            it.channel = ch[0];
            it.rx_byte = plan[ch].pop_front();
            send_item(it, used);
            used_count++;
            if (hold_midway && used_count == target / 2) begin
                push <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
        end
    endtask

    task automatic run_directed();
        logic [7:0] good [16];
        logic [7:0] bad [16];
        logic [7:0] extremes [DATA_BYTES];
        t_item      it;
        bit         used;
        extremes = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                     8'h00, 8'h01, 8'h12, 8'h34, 8'hFF};
        good[0] = SYNC_FIRST_RST;
        good[1] = SYNC_SECOND_RST;
        bad[0]  = SYNC_FIRST_RST;
        bad[1]  = SYNC_SECOND_RST;
        for (int i = 0; i < DATA_BYTES; i++) begin
            good[i + 2] = extremes[i];
            bad[i + 2]  = 8'($urandom);
        end
        good[15] = END_MARKER_RST;
        bad[15]  = ~END_MARKER_RST;
        // second sync byte wrong but equal to the first: drops back to hunting, not taken as a new first sync byte
        it.channel = 1'b1;
        it.rx_byte = SYNC_FIRST_RST;
        send_item(it, used);
        send_item(it, used);
        it.rx_byte = SYNC_SECOND_RST;
        send_item(it, used);
        for (int i = 0; i < 16; i++) begin
            it.channel = 1'b0;
            it.rx_byte = good[i];
            send_item(it, used);
            it.channel = 1'b1;
            it.rx_byte = bad[i];
            send_item(it, used);
        end
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        item_in   <= '0;
        pop       <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= CFG_SYNC_FIRST;
        cfg_wdata <= '0;
        send_idle = 13;
        recv_idle = 83;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(PHASE_BYTES, 1'b1);
        drain();

        write_regs(8'h00, 8'hFF, 8'h00);
        send_idle = 83;
        recv_idle = 13;
        run_random(PHASE_BYTES, 1'b0);
        drain();

        write_regs(8'hFF, 8'h00, 8'hFF);
        send_idle = 0;
        recv_idle = 0;
        run_random(PHASE_BYTES, 1'b0);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
